// ----- src/tspr_pkg.sv -----
package tspr_pkg;

  localparam int SLOTS  = 16;
  localparam int SLOT_W = $clog2(SLOTS);
  localparam int CNT_W  = SLOT_W + 1;
  localparam int TIME_W = 64;

  localparam logic [TIME_W-1:0] TIMEOUT_RST = 64'd1000000000;

  // command codes
  localparam logic [2:0] CMD_START_READ  = 3'd0;
  localparam logic [2:0] CMD_START_WRITE = 3'd1;
  localparam logic [2:0] CMD_WRITE_DONE  = 3'd2;
  localparam logic [2:0] CMD_COMMIT      = 3'd3;
  localparam logic [2:0] CMD_ROLLBACK    = 3'd4;
  localparam logic [2:0] CMD_RELEASE     = 3'd5;
  localparam logic [2:0] CMD_REAP        = 3'd6;

  // status codes
  localparam logic [1:0] ST_DONE      = 2'd0;
  localparam logic [1:0] ST_REFUSED   = 2'd1;
  localparam logic [1:0] ST_EXHAUSTED = 2'd2;

  // slot phases
  localparam logic [2:0] PH_IDLE       = 3'd0;
  localparam logic [2:0] PH_READ       = 3'd1;
  localparam logic [2:0] PH_WRITE      = 3'd2;
  localparam logic [2:0] PH_COMPLETING = 3'd3;
  localparam logic [2:0] PH_COMMITTED  = 3'd4;
  localparam logic [2:0] PH_ROLLED     = 3'd5;

  // one row of the slot table
  typedef struct packed {
    logic [2:0]        phase;
    logic [TIME_W-1:0] start;
    logic [TIME_W-1:0] complete;
  } row_t;

  // write/clear request into the slot table
  typedef struct packed {
    logic              wr_en;
    logic [SLOT_W-1:0] wr_addr;
    row_t              wr_data;
    logic              clr_en;
    logic [SLOT_W-1:0] clr_addr;
  } row_req_t;

endpackage

// ----- src/tspr_slot_mem.sv -----
module tspr_slot_mem (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [tspr_pkg::SLOT_W-1:0] rd_addr,
  output tspr_pkg::row_t             rd_data,
  input  tspr_pkg::row_req_t         req
);

  tspr_pkg::row_t                 mem [tspr_pkg::SLOTS];
  tspr_pkg::row_t                 mem_q;
  logic [tspr_pkg::SLOTS-1:0]     valid;
  logic                           valid_q;

  // row storage, registered read
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    mem_q <= mem[rd_addr];
  end

  // per-row valid bits; an invalid row reads as all zeros
  always_ff @(posedge clk) begin
    if (rst) begin
      valid   <= '0;
      valid_q <= 1'b0;
    end else begin
      if (req.clr_en) begin
        valid[req.clr_addr] <= 1'b0;
      end
      if (req.wr_en) begin
        valid[req.wr_addr] <= 1'b1;
      end
      valid_q <= valid[rd_addr];
    end
  end

  assign rd_data = valid_q ? mem_q : '0;

endmodule

// ----- src/transaction_slot_pool_with_reaping.sv -----
// Write_complete, commit, rollback, refused and unknown commands finish after the row lookup.
// Starts and reap run the reap walk from the oldest age-list entry; a start then pops
// the free stack. Release scans the age list for the slot and moves later entries down.
// A result waits in the done state while the previous result is stalled at the output.
// One command is in flight at a time; the output register lets the next command enter.
// Reset (rst, synchronous) frees slot 0.
module transaction_slot_pool_with_reaping (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [2:0]                    cmd,
  input  logic [3:0]                    slot,
  input  logic [63:0]                   expected_time,
  input  logic [63:0]                   now,
  input  logic [63:0]                   commit_time,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [1:0]                    status,
  output logic [3:0]                    granted_slot,
  output logic [63:0]                   grant_time,
  output logic [4:0]                    freed_count,
  input  logic                          timeout_we,
  input  logic [63:0]                   timeout_wdata
);

  localparam int SW = tspr_pkg::SLOT_W;
  localparam int CW = tspr_pkg::CNT_W;
  localparam int TW = tspr_pkg::TIME_W;

  typedef enum logic [12:0] {
    S_IDLE    = 13'b0000000000001,
    S_LOOK    = 13'b0000000000010,
    S_RP_AGE  = 13'b0000000000100,
    S_RP_ROW  = 13'b0000000001000,
    S_RP_MAX  = 13'b0000000010000,
    S_RP_CMP  = 13'b0000000100000,
    S_GRANT   = 13'b0000001000000,
    S_GRANT2  = 13'b0000010000000,
    S_RL_SCAN = 13'b0000100000000,
    S_RL_CHK  = 13'b0001000000000,
    S_RL_SH   = 13'b0010000000000,
    S_RL_MV   = 13'b0100000000000,
    S_DONE    = 13'b1000000000000
  } state_t;

  state_t            state;
  logic [TW-1:0]     timeout_ns;

  // latched command
  logic [2:0]        cmd_q;
  logic [SW-1:0]     slot_q;
  logic [TW-1:0]     expected_q;
  logic [TW-1:0]     now_q;
  logic [TW-1:0]     ctime_q;

  // working registers
  logic [TW-1:0]     limit;
  logic [TW-1:0]     tmax;
  logic [CW-1:0]     k;
  logic [SW-1:0]     head;
  logic [CW-1:0]     age_depth;
  logic [CW-1:0]     free_depth;

  // result being built
  logic [1:0]        res_status;
  logic [SW-1:0]     res_granted;
  logic [TW-1:0]     res_stime;
  logic [CW-1:0]     res_freed;

  // memories
  logic [SW-1:0]     age_mem [tspr_pkg::SLOTS];
  logic [SW-1:0]     age_q;
  logic [SW-1:0]     age_rd_addr;
  logic              age_we;
  logic [SW-1:0]     age_wr_addr;
  logic [SW-1:0]     age_wr_data;
  logic [SW-1:0]     free_mem [tspr_pkg::SLOTS];
  logic [SW-1:0]     free_q;
  logic [CW-1:0]     free_top;
  logic              free_we;
  logic [SW-1:0]     free_wr_data;

  logic [SW-1:0]     row_rd_addr;
  tspr_pkg::row_t    row_q;
  tspr_pkg::row_req_t row_req;

  logic [TW:0]       diff;
  logic              is_start;
  logic              match;
  logic              ok_wdone;
  logic              ok_commit;
  logic              ok_roll;
  logic              ok_rel;
  logic              pool_empty;
  logic              fresh_push;

  assign in_stall = (state != S_IDLE);

  // decode of the looked-up row
  assign is_start  = (cmd_q == tspr_pkg::CMD_START_READ) || (cmd_q == tspr_pkg::CMD_START_WRITE);
  assign match     = (row_q.start == expected_q);
  assign ok_wdone  = match && (row_q.phase == tspr_pkg::PH_WRITE);
  assign ok_commit = match && ((row_q.phase == tspr_pkg::PH_READ) ||
                               (row_q.phase == tspr_pkg::PH_COMPLETING));
  assign ok_roll   = match && ((row_q.phase == tspr_pkg::PH_READ) ||
                               (row_q.phase == tspr_pkg::PH_WRITE));
  assign ok_rel    = match && (row_q.phase != tspr_pkg::PH_IDLE);
  assign diff      = {1'b0, now_q} - {1'b0, timeout_ns};
  assign pool_empty = (free_depth == '0) || age_depth[CW-1];
  assign fresh_push = (free_depth == '0) && (age_depth < CW'(tspr_pkg::SLOTS - 1));
  assign free_top   = free_depth - CW'(1);

  // read address selection
  always_comb begin
    row_rd_addr = (state == S_IDLE) ? slot : age_q;
    priority if (state == S_RL_SCAN) begin
      age_rd_addr = head + k[SW-1:0];
    end else if (state == S_RL_SH) begin
      age_rd_addr = head + k[SW-1:0] + SW'(1);
    end else begin
      age_rd_addr = head;
    end
  end

  // write requests to the three stores
  always_comb begin
    row_req      = '0;
    age_we       = 1'b0;
    age_wr_addr  = head + k[SW-1:0];
    age_wr_data  = age_q;
    free_we      = 1'b0;
    free_wr_data = slot_q;
    unique case (state)
      S_LOOK: begin
        row_req.wr_addr        = slot_q;
        row_req.wr_data        = row_q;
        row_req.clr_addr       = slot_q;
        if (cmd_q == tspr_pkg::CMD_WRITE_DONE && ok_wdone) begin
          row_req.wr_en            = 1'b1;
          row_req.wr_data.phase    = tspr_pkg::PH_COMPLETING;
          row_req.wr_data.complete = ctime_q;
        end else if (cmd_q == tspr_pkg::CMD_COMMIT && ok_commit) begin
          row_req.wr_en         = 1'b1;
          row_req.wr_data.phase = tspr_pkg::PH_COMMITTED;
        end else if (cmd_q == tspr_pkg::CMD_ROLLBACK && ok_roll) begin
          row_req.wr_en         = 1'b1;
          row_req.wr_data.phase = tspr_pkg::PH_ROLLED;
        end else if (cmd_q == tspr_pkg::CMD_RELEASE && ok_rel) begin
          row_req.clr_en = 1'b1;
          free_we        = !free_depth[CW-1];
        end
      end
      S_RP_CMP: begin
        row_req.clr_addr = age_q;
        free_wr_data     = age_q;
        if (tmax <= limit) begin
          row_req.clr_en = 1'b1;
          free_we        = !free_depth[CW-1];
        end
      end
      S_GRANT2: begin
        row_req.wr_en            = 1'b1;
        row_req.wr_addr          = free_q;
        row_req.wr_data.phase    = (cmd_q == tspr_pkg::CMD_START_READ) ?
                                   tspr_pkg::PH_READ : tspr_pkg::PH_WRITE;
        row_req.wr_data.start    = now_q;
        row_req.wr_data.complete = '0;
        age_we       = 1'b1;
        age_wr_addr  = head + age_depth[SW-1:0];
        age_wr_data  = free_q;
        free_we      = fresh_push;
        free_wr_data = age_depth[SW-1:0] + SW'(1);
      end
      S_RL_MV: begin
        age_we = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // age list and free stack storage; after reset the stack holds slot 0
  always_ff @(posedge clk) begin
    if (age_we) begin
      age_mem[age_wr_addr] <= age_wr_data;
    end
    age_q <= age_mem[age_rd_addr];
    if (rst) begin
      free_mem[0] <= '0;
    end else if (free_we) begin
      free_mem[free_depth[SW-1:0]] <= free_wr_data;
    end
    free_q <= free_mem[free_top[SW-1:0]];
  end

  tspr_slot_mem u_slot_mem (
    .clk     (clk),
    .rst     (rst),
    .rd_addr (row_rd_addr),
    .rd_data (row_q),
    .req     (row_req)
  );

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ns <= tspr_pkg::TIMEOUT_RST;
    end else if (timeout_we) begin
      timeout_ns <= timeout_wdata;
    end
  end

  // command sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      head       <= '0;
      age_depth  <= '0;
      free_depth <= CW'(1);
      out_valid  <= 1'b0;
    end else begin
      if (out_valid && !out_stall && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            cmd_q      <= cmd;
            slot_q     <= slot;
            expected_q <= expected_time;
            now_q      <= now;
            ctime_q    <= commit_time;
            state      <= S_LOOK;
          end
        end
        S_LOOK: begin
          res_granted <= '0;
          res_stime   <= '0;
          res_freed   <= '0;
          limit       <= diff[TW-1:0];
          k           <= '0;
          if (is_start || cmd_q == tspr_pkg::CMD_REAP) begin
            res_status <= (cmd_q == tspr_pkg::CMD_REAP) ? tspr_pkg::ST_DONE :
                                                          tspr_pkg::ST_REFUSED;
            if (diff[TW]) begin
              state <= is_start ? S_GRANT : S_DONE;
            end else begin
              state <= S_RP_AGE;
            end
          end else if ((cmd_q == tspr_pkg::CMD_WRITE_DONE && ok_wdone) ||
                       (cmd_q == tspr_pkg::CMD_COMMIT && ok_commit) ||
                       (cmd_q == tspr_pkg::CMD_ROLLBACK && ok_roll)) begin
            res_status <= tspr_pkg::ST_DONE;
            state      <= S_DONE;
          end else if (cmd_q == tspr_pkg::CMD_RELEASE && ok_rel) begin
            res_status <= tspr_pkg::ST_DONE;
            if (!free_depth[CW-1]) begin
              free_depth <= free_depth + CW'(1);
            end
            state <= S_RL_SCAN;
          end else begin
            res_status <= tspr_pkg::ST_REFUSED;
            state      <= S_DONE;
          end
        end
        // reap walk from the oldest entry
        S_RP_AGE: begin
          if (age_depth == '0) begin
            state <= is_start ? S_GRANT : S_DONE;
          end else begin
            state <= S_RP_ROW;
          end
        end
        S_RP_ROW: begin
          state <= S_RP_MAX;
        end
        S_RP_MAX: begin
          tmax  <= (row_q.start > row_q.complete) ? row_q.start : row_q.complete;
          state <= S_RP_CMP;
        end
        S_RP_CMP: begin
          if (tmax > limit) begin
            state <= is_start ? S_GRANT : S_DONE;
          end else begin
            if (!free_depth[CW-1]) begin
              free_depth <= free_depth + CW'(1);
            end
            head      <= head + SW'(1);
            age_depth <= age_depth - CW'(1);
            res_freed <= res_freed + CW'(1);
            state     <= S_RP_AGE;
          end
        end
        // pop the free stack
        S_GRANT: begin
          if (pool_empty) begin
            res_status <= tspr_pkg::ST_EXHAUSTED;
            state      <= S_DONE;
          end else begin
            free_depth <= free_top;
            state      <= S_GRANT2;
          end
        end
        S_GRANT2: begin
          age_depth   <= age_depth + CW'(1);
          if (fresh_push) begin
            free_depth <= CW'(1);
          end
          res_status  <= tspr_pkg::ST_DONE;
          res_granted <= free_q;
          res_stime   <= now_q;
          state       <= S_DONE;
        end
        // release: find the slot in the age list, then close the gap
        S_RL_SCAN: begin
          state <= (k == age_depth) ? S_DONE : S_RL_CHK;
        end
        S_RL_CHK: begin
          if (age_q == slot_q) begin
            state <= S_RL_SH;
          end else begin
            k     <= k + CW'(1);
            state <= S_RL_SCAN;
          end
        end
        S_RL_SH: begin
          if (k + CW'(1) == age_depth) begin
            age_depth <= age_depth - CW'(1);
            state     <= S_DONE;
          end else begin
            state <= S_RL_MV;
          end
        end
        S_RL_MV: begin
          k     <= k + CW'(1);
          state <= S_RL_SH;
        end
        // hand the result to the output register
        S_DONE: begin
          if (!out_valid || !out_stall) begin
            out_valid    <= 1'b1;
            status       <= res_status;
            granted_slot <= res_granted;
            grant_time   <= res_stime;
            freed_count  <= res_freed;
            state        <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  // between commands the free stack and age list together hold no more slots than exist
  a_slot_count: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |->
      ({1'b0, free_depth} + {1'b0, age_depth}) <= (CW + 1)'(tspr_pkg::SLOTS))
    else $error("free stack and age list hold more slots than exist");

  // an exhausted pool grants nothing
  a_exhausted: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == tspr_pkg::ST_EXHAUSTED |-> granted_slot == '0 && grant_time == '0)
    else $error("exhausted start reports a grant");

  // a refused command never reclaims slots
  a_refused: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == tspr_pkg::ST_REFUSED |-> freed_count == '0)
    else $error("refused command reports reclaimed slots");

  // a result transfer out of the sequencer only happens from the done state
  a_load: assert property (@(posedge clk) disable iff (rst)
    !$past(out_valid) && out_valid |-> $past(state == S_DONE))
    else $error("result loaded outside the done state");
`endif

endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 100ps

// one predicted result of the pool
typedef struct {
  logic [1:0]  status;
  logic [3:0]  granted;
  logic [63:0] stime;
  logic [4:0]  freed;
} pool_result_t;

class slot_pool_board;
  // predicted pool state
  logic [63:0] timeout;
  logic [2:0]  phase [tspr_pkg::SLOTS];
  logic [63:0] t_start [tspr_pkg::SLOTS];
  logic [63:0] t_done [tspr_pkg::SLOTS];
  logic [3:0]  free_stk [tspr_pkg::SLOTS];
  int unsigned free_cnt;
  logic [3:0]  age_list [tspr_pkg::SLOTS];
  int unsigned age_cnt;

  pool_result_t awaited [$];
  int unsigned errors, mismatches, results, grants, exhausted, reaped;

  function new();
    timeout = tspr_pkg::TIMEOUT_RST;
    for (int i = 0; i < tspr_pkg::SLOTS; i++) begin
      phase[i] = tspr_pkg::PH_IDLE;
      t_start[i] = '0;
      t_done[i] = '0;
      free_stk[i] = '0;
      age_list[i] = '0;
    end
    free_cnt = 1;
    age_cnt = 0;
  endfunction

  function void clear_row(int unsigned s);
    phase[s] = tspr_pkg::PH_IDLE;
    t_start[s] = '0;
    t_done[s] = '0;
  endfunction

  function void push_free(int unsigned s);
    if (free_cnt < tspr_pkg::SLOTS) begin
      free_stk[free_cnt] = s[3:0];
      free_cnt++;
    end
  endfunction

  // reclaim the oldest slots that have aged past the timeout
  function int unsigned reap_walk(logic [63:0] t_now);
    int unsigned n;
    int unsigned s;
    logic [63:0] lim;
    logic [63:0] latest;
    n = 0;
    if (t_now < timeout) return 0;
    lim = t_now - timeout;
    while (n < age_cnt) begin
      s = age_list[n];
      latest = (t_start[s] > t_done[s]) ? t_start[s] : t_done[s];
      if (latest > lim) break;
      clear_row(s);
      push_free(s);
      n++;
    end
    for (int k = 0; k + n < age_cnt; k++) age_list[k] = age_list[k + n];
    age_cnt -= n;
    return n;
  endfunction

  // note an accepted command and queue its predicted result
  function void note_input(logic [2:0] c, logic [3:0] s, logic [63:0] ex,
                           logic [63:0] t_now, logic [63:0] ctime);
    pool_result_t r;
    logic match;
    int unsigned g;
    r = '{tspr_pkg::ST_REFUSED, 4'd0, 64'd0, 5'd0};
    match = (t_start[s] == ex);
    case (c)
      tspr_pkg::CMD_START_READ, tspr_pkg::CMD_START_WRITE: begin
        r.freed = 5'(reap_walk(t_now));
        if (free_cnt == 0 || age_cnt >= tspr_pkg::SLOTS) begin
          r.status = tspr_pkg::ST_EXHAUSTED;
          exhausted++;
        end else begin
          free_cnt--;
          g = free_stk[free_cnt];
          age_list[age_cnt] = g[3:0];
          age_cnt++;
          if (free_cnt == 0 && age_cnt < tspr_pkg::SLOTS) push_free(age_cnt);
          phase[g] = (c == tspr_pkg::CMD_START_READ) ? tspr_pkg::PH_READ :
                                                       tspr_pkg::PH_WRITE;
          t_start[g] = t_now;
          r.status = tspr_pkg::ST_DONE;
          r.granted = g[3:0];
          r.stime = t_now;
          grants++;
        end
      end
      tspr_pkg::CMD_WRITE_DONE: if (match && phase[s] == tspr_pkg::PH_WRITE) begin
        phase[s] = tspr_pkg::PH_COMPLETING;
        t_done[s] = ctime;
        r.status = tspr_pkg::ST_DONE;
      end
      tspr_pkg::CMD_COMMIT: if (match && (phase[s] == tspr_pkg::PH_READ ||
                                          phase[s] == tspr_pkg::PH_COMPLETING)) begin
        phase[s] = tspr_pkg::PH_COMMITTED;
        r.status = tspr_pkg::ST_DONE;
      end
      tspr_pkg::CMD_ROLLBACK: if (match && (phase[s] == tspr_pkg::PH_READ ||
                                            phase[s] == tspr_pkg::PH_WRITE)) begin
        phase[s] = tspr_pkg::PH_ROLLED;
        r.status = tspr_pkg::ST_DONE;
      end
      tspr_pkg::CMD_RELEASE: if (match && phase[s] != tspr_pkg::PH_IDLE) begin
        clear_row(s);
        push_free(s);
        for (int k = 0; k < age_cnt; k++) begin
          if (age_list[k] == s) begin
            for (int j = k; j + 1 < age_cnt; j++) age_list[j] = age_list[j + 1];
            age_cnt--;
            break;
          end
        end
        r.status = tspr_pkg::ST_DONE;
      end
      tspr_pkg::CMD_REAP: begin
        r.freed = 5'(reap_walk(t_now));
        r.status = tspr_pkg::ST_DONE;
      end
      default: ;
    endcase
    reaped += r.freed;
    awaited = {awaited, r};
  endfunction

  // compare one transfer from the block with the oldest prediction
  function void check_result(logic [1:0] st, logic [3:0] gs, logic [63:0] stm,
                             logic [4:0] fc);
    pool_result_t e;
    results++;
    if (awaited.size() == 0) begin
      errors++;
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected result: status %0d slot %0d start %0d freed %0d",
                 st, gs, stm, fc);
      return;
    end
    e = awaited.pop_front();
    if (st !== e.status || gs !== e.granted || stm !== e.stime || fc !== e.freed) begin
      errors++;
      mismatches++;
      if (mismatches <= 10)
        $display("result %0d mismatch: exp %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
                 results, e.status, e.granted, e.stime, e.freed, st, gs, stm, fc);
    end
  endfunction
endclass

module tb_top;

  localparam logic [2:0] CMD_UNKNOWN = 3'd7;
  localparam int LIMIT = 1000000;
  localparam int DRAIN = 100;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [2:0]  cmd = '0;
  logic [3:0]  slot = '0;
  logic [63:0] expected_time = '0;
  logic [63:0] now = '0;
  logic [63:0] commit_time = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  status;
  logic [3:0]  granted_slot;
  logic [63:0] grant_time;
  logic [4:0]  freed_count;
  logic        timeout_we = 1'b0;
  logic [63:0] timeout_wdata = '0;

  slot_pool_board pool = new();
  bit          calm = 1'b0;
  int unsigned cycles = 0;
  int unsigned sent = 0;
  logic [63:0] clock_ns;

  transaction_slot_pool_with_reaping i_dut (
    .clk                (clk),
    .rst                (rst),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .cmd                (cmd),
    .slot               (slot),
    .expected_time      (expected_time),
    .now                (now),
    .commit_time        (commit_time),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .status             (status),
    .granted_slot       (granted_slot),
    .grant_time         (grant_time),
    .freed_count        (freed_count),
    .timeout_we         (timeout_we),
    .timeout_wdata      (timeout_wdata)
  );

  always #4 clk = ~clk;

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("tb_top: done, errors");
      $finish;
    end
  end

  // drive one command and wait until it is accepted
  task automatic send_cmd(logic [2:0] c, logic [3:0] s, logic [63:0] ex,
                          logic [63:0] t_now, logic [63:0] ctime);
    int unsigned gap;
    gap = calm ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    cmd <= c;
    slot <= s;
    expected_time <= ex;
    now <= t_now;
    commit_time <= ctime;
    do @(posedge clk); while (in_stall);
    pool.note_input(c, s, ex, t_now, ctime);
    sent++;
    if (sent % 64 == 0) calm = ($urandom_range(0, 3) == 0);
  endtask

  // write the timeout once the pool has gone quiet
  task automatic set_timeout(logic [63:0] v);
    in_valid <= 1'b0;
    while (pool.awaited.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    timeout_we <= 1'b1;
    timeout_wdata <= v;
    @(posedge clk);
    timeout_we <= 1'b0;
    pool.timeout = v;
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // random command, mostly well formed against a slot in use
  task automatic random_cmd(int unsigned step);
    int unsigned pick;
    logic [2:0]  c;
    logic [3:0]  s;
    logic [63:0] ex;
    logic [63:0] t_now;
    clock_ns += $urandom_range(0, step);
    t_now = ($urandom_range(0, 99) < 3) ? rand64() : clock_ns;
    pick = $urandom_range(0, 99);
    if (pick < 35) c = pick[0] ? tspr_pkg::CMD_START_WRITE : tspr_pkg::CMD_START_READ;
    else if (pick < 92)
      c = 3'($urandom_range(tspr_pkg::CMD_WRITE_DONE, tspr_pkg::CMD_RELEASE));
    else if (pick < 97) c = tspr_pkg::CMD_REAP;
    else c = CMD_UNKNOWN;
    if (pool.age_cnt > 0 && $urandom_range(0, 9) < 8)
      s = pool.age_list[$urandom_range(0, pool.age_cnt - 1)];
    else
      s = 4'($urandom_range(0, 15));
    ex = ($urandom_range(0, 9) < 9) ? pool.t_start[s] : rand64();
    send_cmd(c, s, ex, t_now, rand64());
  endtask

  // result side with random stalls
  initial begin
    int unsigned hold;
    @(negedge rst);
    forever begin
      hold = calm ? 0 : $urandom_range(0, 11);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      pool.check_result(status, granted_slot, grant_time, freed_count);
    end
  end

  // stimulus
  initial begin
    logic [63:0] ones;
    logic [63:0] settings [5];
    int unsigned steps [5];
    ones = '1;
    settings = '{64'd0, ones, 64'd200, 64'd5000, tspr_pkg::TIMEOUT_RST};
    steps = '{50, 100000, 100, 2000, 300000000};
    clock_ns = 64'd1000;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: early time, full flow, refusals, extreme times
    send_cmd(tspr_pkg::CMD_START_READ, 4'd0, 64'd0, 64'd0, 64'd0);
    send_cmd(tspr_pkg::CMD_START_WRITE, 4'd0, 64'd0, 64'd1, 64'd0);
    send_cmd(tspr_pkg::CMD_WRITE_DONE, 4'd1, 64'd1, 64'd2, ones);
    send_cmd(tspr_pkg::CMD_COMMIT, 4'd1, 64'd1, 64'd3, 64'd0);
    send_cmd(tspr_pkg::CMD_COMMIT, 4'd0, 64'd0, 64'd3, 64'd0);
    send_cmd(tspr_pkg::CMD_ROLLBACK, 4'd0, 64'd0, 64'd4, 64'd0);
    send_cmd(tspr_pkg::CMD_RELEASE, 4'd1, 64'd7, 64'd5, 64'd0);
    send_cmd(tspr_pkg::CMD_RELEASE, 4'd1, 64'd1, 64'd5, 64'd0);
    send_cmd(tspr_pkg::CMD_START_WRITE, 4'd0, 64'd0, ones, 64'd0);
    send_cmd(tspr_pkg::CMD_ROLLBACK, 4'(pool.age_list[0]), ones, ones, 64'd0);
    send_cmd(tspr_pkg::CMD_WRITE_DONE, 4'd15, 64'd0, 64'd6, 64'd0);
    send_cmd(tspr_pkg::CMD_REAP, 4'd0, 64'd0, 64'd0, 64'd0);
    send_cmd(CMD_UNKNOWN, 4'd15, ones, ones, ones);
    send_cmd(tspr_pkg::CMD_START_READ, 4'd0, 64'd0, 64'd100, 64'd0);
    send_cmd(tspr_pkg::CMD_REAP, 4'd0, 64'd0, ones, 64'd0);

    // random phases over several timeout settings, extremes included
    for (int p = 0; p < 6; p++) begin
      if (p > 0) set_timeout(settings[p - 1]);
      for (int i = 0; i < 215; i++) random_cmd(p == 0 ? 300000000 : steps[p - 1]);
    end

    in_valid <= 1'b0;
    while (pool.awaited.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    $display("covered %0d commands, %0d results: %0d grants, %0d exhausted, %0d reaped",
             sent, pool.results, pool.grants, pool.exhausted, pool.reaped);
    $display("six timeout settings including zero and all ones; %0d mismatches",
             pool.mismatches);
    if (pool.errors == 0 && pool.awaited.size() == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
